[rtl/tsvk_pkg.sv]
// Shared types, constants and helpers for the touch-slot virtual key mapper.
// No dependencies; every other file in rtl imports this package.
package tsvk_pkg;

    // Sizing
    localparam int NUM_SLOTS   = 16;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NUM_KEYS    = 4;
    localparam int KEY_IDX_W   = $clog2(NUM_KEYS);
    localparam int KEY_W       = 48;
    localparam int COORD_W     = 16;
    localparam int CODE_W      = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input event fields
    localparam int EV_TYPE_W  = 5;
    localparam int EV_CODE_W  = 10;
    localparam int EV_VALUE_W = 32;

    localparam logic [EV_TYPE_W-1:0] TYPE_SYNC = 5'd0;
    localparam logic [EV_TYPE_W-1:0] TYPE_KEY  = 5'd1;
    localparam logic [EV_TYPE_W-1:0] TYPE_ABS  = 5'd3;

    localparam logic [EV_CODE_W-1:0] CODE_ABS_X     = 10'h000;
    localparam logic [EV_CODE_W-1:0] CODE_ABS_Y     = 10'h001;
    localparam logic [EV_CODE_W-1:0] CODE_MT_SLOT   = 10'h02f;
    localparam logic [EV_CODE_W-1:0] CODE_MT_X      = 10'h035;
    localparam logic [EV_CODE_W-1:0] CODE_MT_Y      = 10'h036;
    localparam logic [EV_CODE_W-1:0] CODE_MT_TRACK  = 10'h039;
    localparam logic [EV_CODE_W-1:0] CODE_BTN_TOUCH = 10'h14a;

    // Operations passed from the front end to the back end
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_SET_X       = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_Y       = 3'd1;
    localparam logic [OP_W-1:0] OP_ACTIVATE    = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE     = 3'd3;
    localparam logic [OP_W-1:0] OP_RELEASE_ALL = 3'd4;
    localparam logic [OP_W-1:0] OP_SYNC        = 3'd5;

    typedef logic [NUM_KEYS-1:0][KEY_W-1:0] key_array_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] coord;
    } queue_entry_t;

    // Returns the key code whose entry matches (x, y), or zero. Entries with any
    // zero field are disabled; the highest-numbered matching entry wins.
    function automatic logic [CODE_W-1:0] find_key(
        input key_array_t        keys,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y
    );
        logic [CODE_W-1:0]  found;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [CODE_W-1:0]  ec;
        found = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            ex = keys[k][15:0];
            ey = keys[k][31:16];
            ec = keys[k][47:32];
            if ((ex != '0) && (ey != '0) && (ec != '0) && (ex == x) && (ey == y)) begin
                found = ec;
            end
        end
        return found;
    endfunction

endpackage

[rtl/tsvk_front.sv]
// Front end: accepts input events, tracks the selected slot and turns each
// relevant event into an operation for the queue. Depends on tsvk_pkg.
module tsvk_front
    import tsvk_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ev_valid,
    input  logic [EV_TYPE_W-1:0]  ev_type,
    input  logic [EV_CODE_W-1:0]  ev_code,
    input  logic [EV_VALUE_W-1:0] ev_value,
    input  logic                  queue_full,
    output logic                  ev_ready,
    output logic                  push,
    output queue_entry_t          push_entry
);

    logic [SLOT_W-1:0] current_slot_reg;
    logic [SLOT_W-1:0] current_slot_next;
    logic              out_of_range_reg;
    logic              out_of_range_next;

    logic accept;
    logic negative;
    logic slot_ok;
    logic op_valid;

    assign ev_ready = !queue_full;
    assign accept   = ev_valid && ev_ready;
    assign negative = ev_value[EV_VALUE_W-1];
    assign slot_ok  = !out_of_range_reg;

    // Classify the event; slot selection is handled here and never queued.
    always_comb begin
        current_slot_next = current_slot_reg;
        out_of_range_next = out_of_range_reg;
        op_valid          = 1'b0;
        push_entry.op     = OP_SET_X;
        push_entry.slot   = current_slot_reg;
        push_entry.coord  = ev_value[COORD_W-1:0];
        case (ev_type)
            TYPE_ABS: begin
                case (ev_code)
                    CODE_MT_SLOT: begin
                        if (!negative && (ev_value < EV_VALUE_W'(NUM_SLOTS))) begin
                            current_slot_next = ev_value[SLOT_W-1:0];
                            out_of_range_next = 1'b0;
                        end else begin
                            out_of_range_next = 1'b1;
                        end
                    end
                    CODE_MT_TRACK: begin
                        op_valid      = slot_ok;
                        push_entry.op = negative ? OP_RELEASE : OP_ACTIVATE;
                    end
                    CODE_MT_X, CODE_ABS_X: begin
                        op_valid      = slot_ok;
                        push_entry.op = OP_SET_X;
                    end
                    CODE_MT_Y, CODE_ABS_Y: begin
                        op_valid      = slot_ok;
                        push_entry.op = OP_SET_Y;
                    end
                    default: begin
                        op_valid = 1'b0;
                    end
                endcase
            end
            TYPE_KEY: begin
                if (ev_code == CODE_BTN_TOUCH) begin
                    op_valid = 1'b1;
                    if (ev_value != '0) begin
                        push_entry.op   = OP_ACTIVATE;
                        push_entry.slot = '0;
                    end else begin
                        push_entry.op = OP_RELEASE_ALL;
                    end
                end
            end
            TYPE_SYNC: begin
                op_valid      = (ev_value == '0);
                push_entry.op = OP_SYNC;
            end
            default: begin
                op_valid = 1'b0;
            end
        endcase
    end

    assign push = accept && op_valid;

    // Slot selection state changes only on an accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_slot_reg <= '0;
            out_of_range_reg <= 1'b0;
        end else if (accept) begin
            current_slot_reg <= current_slot_next;
            out_of_range_reg <= out_of_range_next;
        end
    end

endmodule

[rtl/tsvk_fifo.sv]
// Short operation queue between the front end and the back end.
// Depends on tsvk_pkg for the entry type and depth.
module tsvk_fifo
    import tsvk_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output logic         full,
    output logic         empty,
    output queue_entry_t head
);

    queue_entry_t      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/tsvk_back.sv]
// Back end: holds the per-slot state, carries out queued operations, walks
// the slots for sync and release-all, and drives the result register.
// Depends on tsvk_pkg.
module tsvk_back
    import tsvk_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  key_array_t        keys,
    input  logic              queue_empty,
    input  queue_entry_t      head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CODE_W-1:0] out_code,
    output logic              out_pressed,
    output logic              out_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [SLOT_W-1:0]  idx_reg;
    logic [SLOT_W-1:0]  idx_next;
    logic [SLOT_W-1:0]  end_reg;
    logic [SLOT_W-1:0]  end_next;
    logic               rel_mode_reg;
    logic               rel_mode_next;

    // Per-slot state
    logic [NUM_SLOTS-1:0] active_reg;
    logic [COORD_W-1:0]   x_reg    [NUM_SLOTS];
    logic [COORD_W-1:0]   y_reg    [NUM_SLOTS];
    logic [CODE_W-1:0]    held_reg [NUM_SLOTS];

    // One result held back so that the final one of a walk can carry last
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [CODE_W-1:0] pend_code_reg;
    logic [CODE_W-1:0] pend_code_next;
    logic              pend_press_reg;
    logic              pend_press_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    logic [CODE_W-1:0] out_code_next;
    logic              out_pressed_reg;
    logic              out_pressed_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic              out_free;
    logic [CODE_W-1:0] found;
    logic              hit;
    logic              stall;
    logic              step;
    logic              wr_x;
    logic              wr_y;
    logic              wr_act;

    assign out_free = !out_valid_reg || out_ready;
    assign found    = find_key(keys, x_reg[idx_reg], y_reg[idx_reg]);
    assign hit      = active_reg[idx_reg]
                      && (rel_mode_reg ? (held_reg[idx_reg] != '0) : (found != '0));
    assign stall    = hit && pend_valid_reg && !out_free;
    assign step     = (state_reg == ST_WALK) && !stall;
    assign pop      = (state_reg == ST_IDLE) && !queue_empty;

    assign wr_x   = pop && (head.op == OP_SET_X);
    assign wr_y   = pop && (head.op == OP_SET_Y);
    assign wr_act = pop && (head.op == OP_ACTIVATE);

    // Sequencer and result path.
    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        end_next         = end_reg;
        rel_mode_next    = rel_mode_reg;
        pend_valid_next  = pend_valid_reg;
        pend_code_next   = pend_code_reg;
        pend_press_next  = pend_press_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_code_next    = out_code_reg;
        out_pressed_next = out_pressed_reg;
        out_last_next    = out_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    case (head.op)
                        OP_RELEASE: begin
                            state_next    = ST_WALK;
                            idx_next      = head.slot;
                            end_next      = head.slot;
                            rel_mode_next = 1'b1;
                        end
                        OP_RELEASE_ALL: begin
                            state_next    = ST_WALK;
                            idx_next      = '0;
                            end_next      = SLOT_W'(NUM_SLOTS - 1);
                            rel_mode_next = 1'b1;
                        end
                        OP_SYNC: begin
                            state_next    = ST_WALK;
                            idx_next      = '0;
                            end_next      = SLOT_W'(NUM_SLOTS - 1);
                            rel_mode_next = 1'b0;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (step) begin
                    if (hit) begin
                        // An earlier result is now known not to be the last one.
                        if (pend_valid_reg) begin
                            out_valid_next   = 1'b1;
                            out_code_next    = pend_code_reg;
                            out_pressed_next = pend_press_reg;
                            out_last_next    = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_code_next  = rel_mode_reg ? held_reg[idx_reg] : found;
                        pend_press_next = !rel_mode_reg;
                    end
                    if (idx_reg == end_reg) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next   = 1'b1;
                    out_code_next    = pend_code_reg;
                    out_pressed_next = pend_press_reg;
                    out_last_next    = 1'b1;
                    pend_valid_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Walk bounds and result payload.
    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        end_reg         <= end_next;
        rel_mode_reg    <= rel_mode_next;
        pend_code_reg   <= pend_code_next;
        pend_press_reg  <= pend_press_next;
        out_code_reg    <= out_code_next;
        out_pressed_reg <= out_pressed_next;
        out_last_reg    <= out_last_next;
    end

    // Slot state: single-slot operations from the queue, walk updates per step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                x_reg[i]    <= '0;
                y_reg[i]    <= '0;
                held_reg[i] <= '0;
            end
        end else begin
            if (wr_x) begin
                x_reg[head.slot] <= head.coord;
            end
            if (wr_y) begin
                y_reg[head.slot] <= head.coord;
            end
            if (wr_act) begin
                active_reg[head.slot] <= 1'b1;
            end
            if (step && active_reg[idx_reg]) begin
                if (rel_mode_reg) begin
                    active_reg[idx_reg] <= 1'b0;
                    held_reg[idx_reg]   <= '0;
                end else if (found != '0) begin
                    held_reg[idx_reg] <= found;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_code    = out_code_reg;
    assign out_pressed = out_pressed_reg;
    assign out_last    = out_last_reg;

endmodule

[rtl/touch_slot_virtual_key_mapper_unit.sv]
// Touch-slot virtual key mapper, top level: configuration registers, front end,
// operation queue and back end. Depends on tsvk_pkg, tsvk_front, tsvk_fifo, tsvk_back.
//
// Multi-touch events enter on the s_ stream and key reports leave on the m_ stream.
// The front end takes one transaction per cycle while the four-entry operation
// queue has room; slot selection and unknown events never reach the queue. The
// back end carries out a position or activation event as it takes it from the
// queue. A tracking-id release takes the operation, visits the slot and issues
// any report; a sync report or touch-button release takes the operation, visits
// one slot per cycle unless stalled and then issues any final report with tlast
// set. A stalled m_ side holds the walk at the next matching slot once both the
// held-back report and the output register are occupied. Key entries are
// written through cfg_we/cfg_addr/cfg_wdata and should only change while no event
// is in flight.
module touch_slot_virtual_key_mapper_unit
    import tsvk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_we,
    input  logic [KEY_IDX_W-1:0] cfg_addr,
    input  logic [KEY_W-1:0]     cfg_wdata,
    // Input events
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // ev_type[4:0], ev_code[14:5], ev_value[46:15]
    // Key reports
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // vkey[15:0]
    output logic                 m_tuser,   // key_pressed[0]
    output logic                 m_tlast
);

    key_array_t   key_reg;
    logic         push;
    logic         pop;
    logic         queue_full;
    logic         queue_empty;
    queue_entry_t push_entry;
    queue_entry_t head;

    // Virtual key entries.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_we) begin
            key_reg[cfg_addr] <= cfg_wdata;
        end
    end

    tsvk_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ev_valid   (s_tvalid),
        .ev_type    (s_tdata[4:0]),
        .ev_code    (s_tdata[14:5]),
        .ev_value   (s_tdata[46:15]),
        .queue_full (queue_full),
        .ev_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    tsvk_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .empty      (queue_empty),
        .head       (head)
    );

    tsvk_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .keys        (key_reg),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_code    (m_tdata),
        .out_pressed (m_tuser),
        .out_last    (m_tlast)
    );

endmodule

[rtl/tsvk_checker.sv]
// Port-level checks for the touch-slot virtual key mapper, bound to the top level.
// Depends on tsvk_pkg and touch_slot_virtual_key_mapper_unit.
module tsvk_checker
    import tsvk_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [CODE_W-1:0]    m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // Reset empties the report register.
    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("report valid after reset");

    // The queue is empty straight after reset, so events are taken at once.
    a_ready_after_reset: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> s_tready)
        else $error("input not ready after reset");

    // Every report names a real key: a zero code is never held nor matched.
    a_code_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata != '0))
        else $error("report with zero key code");

    // A stalled report keeps its contents.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled report changed");

endmodule

bind touch_slot_virtual_key_mapper_unit tsvk_checker u_tsvk_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);
